[rtl/core/best_fit_bin_packer_macros.svh]
// Assertion macros shared by the best-fit bin packer RTL.
`ifndef BEST_FIT_BIN_PACKER_MACROS_SVH
`define BEST_FIT_BIN_PACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BFBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfbp: same-cycle check failed");
`define BFBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfbp: next-cycle check failed");
`else
`define BFBP_ASSERT_NOW(label, ante, cons)
`define BFBP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/bfbp_pkg.sv]
// Shared types and constants of the best-fit bin packer.
`timescale 1ns / 1ps
package bfbp_pkg;

    localparam int SIZE_W   = 16;
    localparam int INDEX_W  = 6;
    localparam int USED_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_EXISTING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOOLARGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic [SIZE_W-1:0] CAP_RESET = 16'hFFFF;

    // Control from the sequencer to the fit unit.
    typedef struct packed {
        logic clear;   // start of a new scan
        logic vld;     // a bin word is presented this cycle
    } t_fit_ctl;

endpackage

[rtl/core/bfbp_fit_unit.sv]
// Shared subtract/compare unit that tracks the tightest fitting bin of a scan.
`timescale 1ns / 1ps
module bfbp_fit_unit #(
    parameter int AW = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfbp_pkg::t_fit_ctl          i_ctl,
    input  logic [AW-1:0]               i_idx,
    input  logic [bfbp_pkg::SIZE_W-1:0] i_space,
    input  logic [bfbp_pkg::SIZE_W-1:0] i_size,
    output logic                        o_found,
    output logic [AW-1:0]               o_best_idx,
    output logic [bfbp_pkg::SIZE_W-1:0] o_best_left
);

    logic                        r_found;
    logic [AW-1:0]               r_best_idx;
    logic [bfbp_pkg::SIZE_W-1:0] r_best_left;

    logic [bfbp_pkg::SIZE_W:0]   diff;
    logic                        fits;
    logic                        better;

    // Borrow out of the subtract says the item does not fit.
    assign diff   = {1'b0, i_space} - {1'b0, i_size};
    assign fits   = ~diff[bfbp_pkg::SIZE_W];
    assign better = fits && (!r_found || (diff[bfbp_pkg::SIZE_W-1:0] < r_best_left));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.vld && better) begin
            r_found <= 1'b1;
        end
    end

    // Strict less-than keeps the lowest index on ties.
    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && i_ctl.vld && better) begin
            r_best_idx  <= i_idx;
            r_best_left <= diff[bfbp_pkg::SIZE_W-1:0];
        end
    end

    assign o_found     = r_found;
    assign o_best_idx  = r_best_idx;
    assign o_best_left = r_best_left;

endmodule

[rtl/core/best_fit_bin_packer.sv]
// Best-fit bin packer: one bin scanned per cycle from a bin table with one write and one read port.
// Flow: an item is scanned against every open bin (skipped for an oversized
// item), then decided in the final state; busy drops in the o_done strobe cycle.
// A new item is accepted only while busy is low, as the scan reads one table entry per cycle.
// Reset clears the open-bin count and sequencer; bin_capacity resets to 65535.
// The receiver cannot stall: o_done marks a result valid for one cycle.
`timescale 1ns / 1ps
`include "best_fit_bin_packer_macros.svh"
module best_fit_bin_packer #(
    parameter int MAX_BINS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command side
    input  logic                          start,
    output logic                          busy,
    input  logic [bfbp_pkg::SIZE_W-1:0]   i_item_size,
    input  logic                          i_last_item,
    // result side
    output logic                          o_done,
    output logic [bfbp_pkg::INDEX_W-1:0]  o_bin_index,
    output logic [bfbp_pkg::USED_W-1:0]   o_bins_used,
    output logic [bfbp_pkg::STATUS_W-1:0] o_place_status,
    output logic [bfbp_pkg::SIZE_W-1:0]   o_space_left,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int SW = bfbp_pkg::SIZE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [1:0] ADDR_CAP = 2'd0;

    logic [1:0]    r_state;
    logic [SW-1:0] r_cap;
    logic [CW-1:0] r_open;
    logic [CW-1:0] r_cnt;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic [SW-1:0] r_rd_data;
    logic [SW-1:0] r_size;
    logic          r_last;
    logic          r_too_large;
    logic          r_done;
    logic [bfbp_pkg::INDEX_W-1:0]  r_bin_index;
    logic [bfbp_pkg::USED_W-1:0]   r_bins_used;
    logic [bfbp_pkg::STATUS_W-1:0] r_status;
    logic [SW-1:0] r_space_left;

    logic [SW-1:0] r_mem [MAX_BINS];

    logic                accept;
    logic                cfg_wr;
    logic                issue;
    bfbp_pkg::t_fit_ctl  fit_ctl;
    logic                fit_found;
    logic [AW-1:0]       fit_idx;
    logic [SW-1:0]       fit_left;

    logic                          fin_we;
    logic [AW-1:0]                 fin_idx;
    logic [SW-1:0]                 fin_left;
    logic [bfbp_pkg::STATUS_W-1:0] fin_status;
    logic [CW-1:0]                 fin_open;
    logic [AW+bfbp_pkg::INDEX_W-1:0] fin_idx_ext;
    logic [CW+bfbp_pkg::USED_W-1:0]  fin_open_ext;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = {16'h0000, r_cap};

    assign issue = (r_state == S_SCAN) && (r_cnt < r_open);

    assign fit_ctl.clear = accept;
    assign fit_ctl.vld   = r_rd_vld;

    bfbp_fit_unit #(
        .AW(AW)
    ) u_fit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (fit_ctl),
        .i_idx      (r_rd_idx),
        .i_space    (r_rd_data),
        .i_size     (r_size),
        .o_found    (fit_found),
        .o_best_idx (fit_idx),
        .o_best_left(fit_left)
    );

    // Placement decision, valid in the final state.
    always_comb begin
        fin_we     = 1'b0;
        fin_idx    = '0;
        fin_left   = '0;
        fin_status = bfbp_pkg::ST_FULL;
        fin_open   = r_open;
        priority if (r_too_large) begin
            fin_status = bfbp_pkg::ST_TOOLARGE;
        end else if (fit_found) begin
            fin_we     = 1'b1;
            fin_idx    = fit_idx;
            fin_left   = fit_left;
            fin_status = bfbp_pkg::ST_EXISTING;
        end else if (r_open < CW'(MAX_BINS)) begin
            fin_we     = 1'b1;
            fin_idx    = r_open[AW-1:0];
            fin_left   = r_cap - r_size;
            fin_status = bfbp_pkg::ST_NEW;
            fin_open   = r_open + CW'(1);
        end else begin
            fin_status = bfbp_pkg::ST_FULL;
        end
    end

    // Fit the index and count to the result field widths.
    assign fin_idx_ext  = {{bfbp_pkg::INDEX_W{1'b0}}, fin_idx};
    assign fin_open_ext = {{bfbp_pkg::USED_W{1'b0}}, fin_open};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bfbp_pkg::CAP_RESET;
        end else if (cfg_wr && (paddr == ADDR_CAP)) begin
            r_cap <= pwdata[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN);
            unique case (r_state)
                S_IDLE: begin
                    r_cnt    <= '0;
                    r_rd_vld <= 1'b0;
                    if (accept) begin
                        r_state <= (i_item_size > r_cap) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= issue;
                    if (issue) begin
                        r_cnt <= r_cnt + CW'(1);
                    end else if (!r_rd_vld) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_open  <= r_last ? '0 : fin_open;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_size      <= i_item_size;
            r_last      <= i_last_item;
            r_too_large <= (i_item_size > r_cap);
        end
        r_rd_idx <= r_cnt[AW-1:0];
        if (r_state == S_FIN) begin
            r_bin_index  <= fin_idx_ext[bfbp_pkg::INDEX_W-1:0];
            r_bins_used  <= fin_open_ext[bfbp_pkg::USED_W-1:0];
            r_status     <= fin_status;
            r_space_left <= fin_left;
        end
    end

    // Bin table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && fin_we) begin
            r_mem[fin_idx] <= fin_left;
        end
        r_rd_data <= r_mem[r_cnt[AW-1:0]];
    end

    assign o_done         = r_done;
    assign o_bin_index    = r_bin_index;
    assign o_bins_used    = r_bins_used;
    assign o_place_status = r_status;
    assign o_space_left   = r_space_left;

    `BFBP_ASSERT_NOW(a_reject_zero, o_done && ((o_place_status == bfbp_pkg::ST_TOOLARGE) || (o_place_status == bfbp_pkg::ST_FULL)), (o_bin_index == '0) && (o_space_left == '0))
    `BFBP_ASSERT_NEXT(a_fin_strobes, r_state == S_FIN, o_done && !busy)
    `BFBP_ASSERT_NEXT(a_accept_busy, accept, busy)
    `BFBP_ASSERT_NOW(a_open_bound, 1'b1, r_open <= CW'(MAX_BINS))
    `BFBP_ASSERT_NOW(a_scan_bound, r_state == S_SCAN, r_cnt <= r_open)

endmodule
